@@ hdl/tpg_pkg.sv @@
// Shared types, constants and the wave-center table for the tile pattern generator.
// No dependencies; every other file imports this package.
`default_nettype none
package tpg_pkg;

   localparam int TileWDef = 32;
   localparam int TileHDef = 32;

   localparam int CoordW   = 5;
   localparam int ColorW   = 16;
   localparam int ModeW    = 4;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 16;
   localparam int LfsrW    = 16;

   localparam logic [ModeW-1:0] ModeSolid       = 4'd0;
   localparam logic [ModeW-1:0] ModeVGradient   = 4'd1;
   localparam logic [ModeW-1:0] ModeHGradient   = 4'd2;
   localparam logic [ModeW-1:0] ModeChecker     = 4'd3;
   localparam logic [ModeW-1:0] ModeNoise       = 4'd4;
   localparam logic [ModeW-1:0] ModeDiagonal    = 4'd5;
   localparam logic [ModeW-1:0] ModeTransparent = 4'd6;
   localparam logic [ModeW-1:0] ModeWaves       = 4'd7;
   localparam logic [ModeW-1:0] ModeTriangles   = 4'd8;
   localparam logic [ModeW-1:0] ModeDots        = 4'd9;

   localparam logic [CsrIdxW-1:0] CsrPatternMode    = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrPrimaryColor   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrSecondaryColor = 2'd2;

   localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;
   localparam logic [LfsrW-1:0] LfsrTaps = 16'hB400;

   typedef struct packed {
      logic advance;
      logic use_h;
   } grad_ctl_type;

   // Center row of the sine band for each column.
   function automatic logic [CoordW-1:0] wave_center(input logic [CoordW-1:0] col);
      logic [CoordW-1:0] c;
      begin
         case (col)
            5'd0:  c = 5'd16;  5'd1:  c = 5'd17;  5'd2:  c = 5'd19;  5'd3:  c = 5'd20;
            5'd4:  c = 5'd21;  5'd5:  c = 5'd22;  5'd6:  c = 5'd23;  5'd7:  c = 5'd23;
            5'd8:  c = 5'd24;  5'd9:  c = 5'd23;  5'd10: c = 5'd23;  5'd11: c = 5'd22;
            5'd12: c = 5'd21;  5'd13: c = 5'd20;  5'd14: c = 5'd19;  5'd15: c = 5'd17;
            5'd16: c = 5'd15;  5'd17: c = 5'd14;  5'd18: c = 5'd12;  5'd19: c = 5'd11;
            5'd20: c = 5'd10;  5'd21: c = 5'd9;   5'd22: c = 5'd8;   5'd23: c = 5'd8;
            5'd24: c = 5'd8;   5'd25: c = 5'd8;   5'd26: c = 5'd8;   5'd27: c = 5'd9;
            5'd28: c = 5'd10;  5'd29: c = 5'd11;  5'd30: c = 5'd12;  5'd31: c = 5'd14;
            default: c = 5'd16;
         endcase
         return c;
      end
   endfunction

endpackage
`default_nettype wire

@@ hdl/tpg_grad_div.sv @@
// Two-stage gradient datapath: scaled color difference, then division by tile size minus one
// through a constant reciprocal. Depends on tpg_pkg.
`default_nettype none
module tpg_grad_div #(
   parameter int TileW = tpg_pkg::TileWDef,
   parameter int TileH = tpg_pkg::TileHDef
) (
   input  logic                         clock,
   input  tpg_pkg::grad_ctl_type        ctl,
   input  logic [tpg_pkg::ColorW-1:0]   primary,
   input  logic [tpg_pkg::ColorW-1:0]   secondary,
   input  logic [tpg_pkg::CoordW-1:0]   k,
   output logic [tpg_pkg::ColorW-1:0]   offset
);
   import tpg_pkg::*;

   localparam int ProdW   = ColorW + CoordW;
   localparam int RecipW  = ProdW + 2;
   localparam int FullW   = ProdW + RecipW;
   localparam int DivX    = TileW - 1;
   localparam int DivY    = TileH - 1;
   localparam int ShiftX  = ProdW + $clog2(DivX);
   localparam int ShiftY  = ProdW + $clog2(DivY);
   localparam int ShiftMx = (ShiftX > ShiftY) ? ShiftX : ShiftY;
   localparam int ShAmtW  = $clog2(ShiftMx + 1);
   localparam longint RecipXWide = ((longint'(1) <<< ShiftX) + longint'(DivX) - 1) / longint'(DivX);
   localparam longint RecipYWide = ((longint'(1) <<< ShiftY) + longint'(DivY) - 1) / longint'(DivY);
   localparam logic [RecipW-1:0] RecipX = RecipW'(RecipXWide);
   localparam logic [RecipW-1:0] RecipY = RecipW'(RecipYWide);

   logic signed [ColorW:0]  diff;
   logic [ColorW-1:0]       mag;
   logic [ProdW-1:0]        prod_in, prod_ff;
   logic                    neg_in, neg_ff;
   logic [RecipW-1:0]       recip_in, recip_ff;
   logic [ShAmtW-1:0]       shamt_in, shamt_ff;
   logic [FullW-1:0]        quot_full;
   logic [FullW-1:0]        quot_mag;
   logic [ColorW-1:0]       quot_lo;

   always_comb begin
      diff     = $signed({1'b0, secondary}) - $signed({1'b0, primary});
      neg_in   = diff[ColorW];
      mag      = neg_in ? ColorW'(-diff) : diff[ColorW-1:0];
      prod_in  = ProdW'(mag) * ProdW'(k);
      recip_in = ctl.use_h ? RecipX : RecipY;
      shamt_in = ctl.use_h ? ShAmtW'(ShiftX) : ShAmtW'(ShiftY);
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff  <= prod_in;
         neg_ff   <= neg_in;
         recip_ff <= recip_in;
         shamt_ff <= shamt_in;
      end
   end

   always_comb begin
      quot_full = FullW'(prod_ff) * FullW'(recip_ff);
      quot_mag  = quot_full >> shamt_ff;
      quot_lo   = quot_mag[ColorW-1:0];
      offset    = neg_ff ? ColorW'(-quot_lo) : quot_lo;
   end

endmodule
`default_nettype wire

@@ hdl/tile_pattern_generator.sv @@
// Top level of the tile pattern generator: register file, pattern logic and result register.
// Depends on tpg_pkg and tpg_grad_div.
//
//   Port group   Dir   Contents
//   req_*        in    tdata: pixel_x [4:0], pixel_y [9:5], zero pad [15:10]
//   rsp_*        out   tdata: pixel_color [15:0]; tuser: write_enable
//   csr_*        in    csr_we, csr_index, csr_wdata (pattern_mode, primary, secondary)
//
// One item is taken per clock while req_tready is high; each result passes through every stage below.
// The three pipeline stages (input, gradient product, result) advance together.
// req_tready falls only while the result register holds an item that is not taken.
// Synchronous reset clears the configuration registers and the valid bits and reloads the
// noise LFSR seed.
`default_nettype none
module tile_pattern_generator #(
   parameter int TileW = tpg_pkg::TileWDef,
   parameter int TileH = tpg_pkg::TileHDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tpg_pkg::ReqDataW-1:0]   req_tdata,   // pixel_x, pixel_y, pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tpg_pkg::ColorW-1:0]     rsp_tdata,   // pixel_color
   output logic                           rsp_tuser,   // write_enable
   input  logic                           csr_we,
   input  logic [tpg_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [tpg_pkg::CsrDataW-1:0]   csr_wdata
);
   import tpg_pkg::*;

   logic [ModeW-1:0]    mode_ff;
   logic [ColorW-1:0]   primary_ff, secondary_ff;
   logic [LfsrW-1:0]    lfsr_ff, lfsr_in, lfsr_step;
   logic                advance;

   logic                s1_valid_ff;
   logic [CoordW-1:0]   s1_x_ff, s1_y_ff;
   logic                s2_valid_ff;
   logic [ColorW-1:0]   s2_color_ff, s2_color_in;
   logic                s2_we_ff, s2_we_in;
   logic                s2_grad_ff, s2_grad_in;
   logic                rsp_valid_ff;
   logic [ColorW-1:0]   rsp_color_ff, rsp_color_in;
   logic                rsp_we_ff;

   logic [CoordW-1:0]   sum_xy;
   logic [CoordW-1:0]   center;
   logic signed [CoordW:0] band_dist;
   logic                take_primary;
   grad_ctl_type        grad_ctl;
   logic [ColorW-1:0]   grad_offset;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_we_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModeSolid;
         primary_ff   <= '0;
         secondary_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrPatternMode:    mode_ff      <= csr_wdata[ModeW-1:0];
            CsrPrimaryColor:   primary_ff   <= csr_wdata[ColorW-1:0];
            CsrSecondaryColor: secondary_ff <= csr_wdata[ColorW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lfsr_step = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LfsrTaps) : (lfsr_ff >> 1);
      lfsr_in   = (advance && s1_valid_ff && (mode_ff == ModeNoise)) ? lfsr_step : lfsr_ff;

      sum_xy    = s1_x_ff + s1_y_ff;
      center    = wave_center(s1_x_ff);
      band_dist = $signed({1'b0, s1_y_ff}) - $signed({1'b0, center});

      s2_we_in     = 1'b1;
      s2_grad_in   = 1'b0;
      take_primary = 1'b1;
      case (mode_ff)
         ModeVGradient:   s2_grad_in   = 1'b1;
         ModeHGradient:   s2_grad_in   = 1'b1;
         ModeChecker:     take_primary = (s1_x_ff[2] ^ s1_y_ff[2]) == 1'b0;
         ModeNoise:       take_primary = lfsr_step[0];
         ModeDiagonal:    take_primary = !sum_xy[2];
         ModeTransparent: s2_we_in     = 1'b0;
         ModeWaves:       take_primary = (band_dist > 6'sd2) || (band_dist < -6'sd2);
         ModeTriangles:   take_primary = !sum_xy[3];
         ModeDots:        take_primary = (s1_x_ff[1:0] == 2'd0) && (s1_y_ff[1:0] == 2'd0);
         default:         take_primary = 1'b1;
      endcase
      s2_color_in = !s2_we_in ? '0 : (take_primary ? primary_ff : secondary_ff);

      grad_ctl.advance = advance;
      grad_ctl.use_h   = (mode_ff == ModeHGradient);

      rsp_color_in = s2_grad_ff ? (primary_ff + grad_offset) : s2_color_ff;
   end

   tpg_grad_div #(
      .TileW(TileW),
      .TileH(TileH)
   ) u_grad_div (
      .clock     (clock),
      .ctl       (grad_ctl),
      .primary   (primary_ff),
      .secondary (secondary_ff),
      .k         (grad_ctl.use_h ? s1_x_ff : s1_y_ff),
      .offset    (grad_offset)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff      <= LfsrSeed;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lfsr_ff <= lfsr_in;
         if (advance) begin
            s1_valid_ff  <= req_tvalid;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff      <= req_tdata[CoordW-1:0];
         s1_y_ff      <= req_tdata[2*CoordW-1:CoordW];
         s2_color_ff  <= s2_color_in;
         s2_we_ff     <= s2_we_in;
         s2_grad_ff   <= s2_grad_in;
         rsp_color_ff <= rsp_color_in;
         rsp_we_ff    <= s2_we_ff;
      end
   end

endmodule
`default_nettype wire

@@ hdl/tpg_checker.sv @@
// Port-level checks for the tile pattern generator, attached by the bind below.
// Depends on tpg_pkg and tile_pattern_generator.
`default_nettype none
module tpg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [tpg_pkg::ColorW-1:0]    rsp_tdata,
   input logic                          rsp_tuser
);
   import tpg_pkg::*;

   // No result may be shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A transparent pixel always carries a zero color.
   a_transparent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("transparent item with nonzero color");

   // With the result register empty or draining, the input side must be open.
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while output is free");

endmodule

bind tile_pattern_generator tpg_checker u_tpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
